// ----- hdl/bmp_mono_pkg.sv -----
// Package: types, constants and helper functions of the BMP row to mono hex core.
`default_nettype none
package bmp_mono_pkg;

  localparam int DEF_PALETTE_DEPTH = 256;
  localparam int DEF_LINE_BYTES    = 32;
  localparam int DEF_MAX_WIDTH     = 8192;

  localparam int CFG_DATA_W  = 14;
  localparam int CFG_INDEX_W = 2;
  localparam int ROW_COUNT_W = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_BPP_CODE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_COLOR = 2'd2;

  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_DATA    = 1'b1;

  localparam logic [2:0] COLOR_BLACK = 3'd0;
  localparam logic [2:0] COLOR_WHITE = 3'd1;
  localparam logic [2:0] COLOR_RED   = 3'd2;
  localparam logic [2:0] COLOR_GREEN = 3'd3;

  localparam logic [2:0] BPP_1 = 3'd0;
  localparam logic [2:0] BPP_2 = 3'd1;
  localparam logic [2:0] BPP_4 = 3'd2;
  localparam logic [2:0] BPP_8 = 3'd3;

  localparam logic [7:0] LOW_LEVEL  = 8'd85;
  localparam logic [7:0] HIGH_LEVEL = 8'd170;

  localparam logic [6:0] ASCII_ZERO   = 7'd48;
  localparam logic [6:0] ASCII_A_BASE = 7'd87;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RGB,
    ST_FINISH
  } state_t;

  // true when the pixel does not match the selected color
  function automatic logic pixel_off(input logic [2:0] color, input logic [7:0] b,
                                     input logic [7:0] g, input logic [7:0] r);
    logic on;
    case (color)
      COLOR_BLACK: on = (b < LOW_LEVEL) && (g < LOW_LEVEL) && (r < LOW_LEVEL);
      COLOR_WHITE: on = (b > HIGH_LEVEL) && (g > HIGH_LEVEL) && (r > HIGH_LEVEL);
      COLOR_RED:   on = (r > HIGH_LEVEL) && ((b < LOW_LEVEL) || (g < LOW_LEVEL));
      COLOR_GREEN: on = (g > HIGH_LEVEL) && ((r < LOW_LEVEL) || (b < LOW_LEVEL));
      default:     on = (b > HIGH_LEVEL) && ((r < LOW_LEVEL) || (g < LOW_LEVEL));
    endcase
    return !on;
  endfunction

  function automatic logic [6:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) begin
      return ASCII_ZERO + {3'b000, n};
    end
    return ASCII_A_BASE + {3'b000, n};
  endfunction

endpackage
`default_nettype wire

// ----- hdl/bmp_row_to_mono_hex_core.sv -----
// Top level: BMP bitmap rows to 1 bit per pixel packed bytes as ASCII hex digits.
//
// Input channel (in_valid / in_stall): a request with cmd 0 loads one palette
// entry and leaves the core idle. A request with cmd 1 carries one raw bitmap
// byte. At 1, 2, 4 or 8 bits per pixel the byte holds per = 8 / bits per pixel
// pixels: one synchronous palette read per pixel, each classified and packed in
// the cycle after its read; the scan ends early once a packed byte completes or
// the row's pixels run out. At 24 bits per pixel a byte passes the RGB step.
// Configuration writes go through cfg_write / cfg_index / cfg_data; the user
// must write them only while the core is idle, the core does not enforce it;
// a write of the bits-per-pixel register restarts the row.
// Output channel (out_valid / out_stall): one request per packed byte, two hex
// digits and the line end flag, registered. The core takes the next input
// request while a result waits; it holds in its last step only when a second
// result is ready and the output register is still stalled.
// Reset clears all row counters, selects 1 bpp and black, sets the row width
// to 1; the palette is undefined until written.
`default_nettype none
module bmp_row_to_mono_hex_core
  import bmp_mono_pkg::*;
#(
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH,
  parameter int LINE_BYTES    = DEF_LINE_BYTES,
  parameter int MAX_WIDTH     = DEF_MAX_WIDTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   cmd,
  input  wire logic [7:0]             data_byte,
  input  wire logic [7:0]             palette_index,
  input  wire logic [7:0]             pal_blue,
  input  wire logic [7:0]             pal_green,
  input  wire logic [7:0]             pal_red,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [6:0]                  hex_high,
  output logic [6:0]                  hex_low,
  output logic                        line_end
);

  localparam int PAL_AW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int WIDTH_W = $clog2(MAX_WIDTH + 1);
  localparam int LINE_W  = $clog2(LINE_BYTES + 1);
  localparam int BITS_W  = $clog2(MAX_WIDTH * 24 + 32);
  localparam int SW      = (BITS_W > ROW_COUNT_W) ? BITS_W : ROW_COUNT_W;

  state_t state, state_next;

  logic [2:0]               bpp_code;
  logic [13:0]              row_width;
  logic [2:0]               pixel_color;
  logic [WIDTH_W-1:0]       width_eff, width_eff_next;
  logic [SW-1:0]            stride, stride_next;
  logic [SW-1:0]            row_bits;

  logic [23:0]              palette_mem [PALETTE_DEPTH];
  logic [23:0]              pal_rdata;
  logic                     pal_oor;
  logic                     pal_we;

  logic [7:0]               byte_q;
  logic [3:0]               rd_k;
  logic [2:0]               proc_k;
  logic                     proc_valid;
  logic [3:0]               per;
  logic [2:0]               shamt;
  logic [7:0]               shifted;
  logic [7:0]               rd_idx;
  logic                     issue;

  logic [WIDTH_W-1:0]       column, column_next;
  logic [ROW_COUNT_W-1:0]   row_cnt, row_cnt_next, row_inc;
  logic [7:0]               packed_bits, packed_next;
  logic [2:0]               bit_pos, bit_pos_next;
  logic [LINE_W-1:0]        line_cnt, line_cnt_next, line_inc;
  logic [15:0]              gather, gather_next;
  logic [1:0]               phase, phase_next;
  logic                     emit_q, emit_next;

  logic                     accept, is_rgb, active, scan_done, out_free, finish_go;
  logic                     pix_do, pix_emit, le;
  logic [7:0]               pix_b, pix_g, pix_r;
  logic [WIDTH_W-1:0]       col_inc;
  logic                     out_load;
  logic [6:0]               hex_high_next, hex_low_next;
  logic                     line_end_next;

  assign accept   = in_valid && !in_stall;
  assign is_rgb   = bpp_code inside {[3'd4:3'd7]};
  assign out_free = !out_valid || !out_stall;
  assign pal_we   = accept && (cmd == CMD_PALETTE) && ({1'b0, palette_index} < 9'(PALETTE_DEPTH));

  // effective width and row stride
  always_comb begin
    if (row_width == '0) begin
      width_eff_next = WIDTH_W'(1);
    end else if (32'(row_width) > 32'(MAX_WIDTH)) begin
      width_eff_next = WIDTH_W'(MAX_WIDTH);
    end else begin
      width_eff_next = WIDTH_W'(row_width);
    end
    case (bpp_code)
      BPP_1:   row_bits = SW'(width_eff_next);
      BPP_2:   row_bits = SW'(width_eff_next) << 1;
      BPP_4:   row_bits = SW'(width_eff_next) << 2;
      BPP_8:   row_bits = SW'(width_eff_next) << 3;
      default: row_bits = (SW'(width_eff_next) << 4) + (SW'(width_eff_next) << 3);
    endcase
    stride_next = ((row_bits + SW'(31)) >> 5) << 2;
  end

  // palette index of the pixel being read
  always_comb begin
    per     = 4'd8 >> bpp_code[1:0];
    shamt   = 3'(rd_k[2:0] << bpp_code[1:0]);
    shifted = byte_q << shamt;
    case (bpp_code[1:0])
      2'd0:    rd_idx = {7'b0, shifted[7]};
      2'd1:    rd_idx = {6'b0, shifted[7:6]};
      2'd2:    rd_idx = {4'b0, shifted[7:4]};
      default: rd_idx = shifted;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (cmd == CMD_DATA)) begin
          state_next = is_rgb ? ST_RGB : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_RGB: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = (state != ST_IDLE);
    issue     = (state == ST_SCAN) && (rd_k < per);
    finish_go = (state == ST_FINISH) && (!emit_q || out_free);
  end

  // pixel classify, pack, emit and row bookkeeping
  always_comb begin
    active = column < width_eff;
    pix_do = 1'b0;
    pix_b  = pal_oor ? 8'd0 : pal_rdata[7:0];
    pix_g  = pal_oor ? 8'd0 : pal_rdata[15:8];
    pix_r  = pal_oor ? 8'd0 : pal_rdata[23:16];

    column_next   = column;
    packed_next   = packed_bits;
    bit_pos_next  = bit_pos;
    line_cnt_next = line_cnt;
    row_cnt_next  = row_cnt;
    gather_next   = gather;
    phase_next    = phase;
    emit_next     = emit_q;
    out_load      = 1'b0;
    le            = 1'b0;
    line_inc      = line_cnt + LINE_W'(1);
    row_inc       = row_cnt + ROW_COUNT_W'(1);
    col_inc       = column + WIDTH_W'(1);

    if (accept) begin
      emit_next = 1'b0;
    end

    if (state == ST_SCAN) begin
      pix_do = proc_valid && active;
    end else if ((state == ST_RGB) && active) begin
      case (phase)
        2'd0: begin
          gather_next = {gather[15:8], byte_q};
          phase_next  = 2'd1;
        end
        2'd1: begin
          gather_next = {byte_q, gather[7:0]};
          phase_next  = 2'd2;
        end
        default: begin
          phase_next = 2'd0;
          pix_do     = 1'b1;
          pix_b      = gather[7:0];
          pix_g      = gather[15:8];
          pix_r      = byte_q;
        end
      endcase
    end

    pix_emit = (bit_pos == 3'd7) || (col_inc >= width_eff);
    if (pix_do) begin
      if (pixel_off(pixel_color, pix_b, pix_g, pix_r)) begin
        packed_next = packed_bits | (8'h80 >> bit_pos);
      end
      bit_pos_next = bit_pos + 3'd1;
      column_next  = col_inc;
      emit_next    = pix_emit;
    end

    scan_done = proc_valid && (!active || pix_emit || ({1'b0, proc_k} == per - 4'd1));

    if (finish_go) begin
      if (emit_q) begin
        le            = (32'(line_inc) >= 32'(LINE_BYTES)) || (column >= width_eff);
        line_cnt_next = le ? '0 : line_inc;
        packed_next   = '0;
        bit_pos_next  = '0;
        out_load      = 1'b1;
      end
      row_cnt_next = row_inc;
      if (SW'(row_inc) >= stride) begin
        column_next   = '0;
        row_cnt_next  = '0;
        packed_next   = '0;
        bit_pos_next  = '0;
        line_cnt_next = '0;
        gather_next   = '0;
        phase_next    = '0;
      end
    end

    // restart the row on a bits-per-pixel write
    if (cfg_write && (cfg_index == REG_BPP_CODE)) begin
      column_next   = '0;
      row_cnt_next  = '0;
      packed_next   = '0;
      bit_pos_next  = '0;
      line_cnt_next = '0;
      gather_next   = '0;
      phase_next    = '0;
    end

    hex_high_next = hex_digit(packed_bits[7:4]);
    hex_low_next  = hex_digit(packed_bits[3:0]);
    line_end_next = le;
  end

  // palette memory
  always_ff @(posedge clk) begin
    if (pal_we) begin
      palette_mem[palette_index[PAL_AW-1:0]] <= {pal_red, pal_green, pal_blue};
    end
    pal_rdata <= palette_mem[rd_idx[PAL_AW-1:0]];
    pal_oor   <= {1'b0, rd_idx} >= 9'(PALETTE_DEPTH);
  end

  // payload registers
  always_ff @(posedge clk) begin
    width_eff <= width_eff_next;
    stride    <= stride_next;
    proc_k    <= rd_k[2:0];
    if (accept) begin
      byte_q <= data_byte;
    end
    if (out_load) begin
      hex_high <= hex_high_next;
      hex_low  <= hex_low_next;
      line_end <= line_end_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      bpp_code    <= '0;
      row_width   <= 14'd1;
      pixel_color <= '0;
      column      <= '0;
      row_cnt     <= '0;
      packed_bits <= '0;
      bit_pos     <= '0;
      line_cnt    <= '0;
      gather      <= '0;
      phase       <= '0;
      emit_q      <= 1'b0;
      rd_k        <= '0;
      proc_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      column      <= column_next;
      row_cnt     <= row_cnt_next;
      packed_bits <= packed_next;
      bit_pos     <= bit_pos_next;
      line_cnt    <= line_cnt_next;
      gather      <= gather_next;
      phase       <= phase_next;
      emit_q      <= emit_next;
      if (accept) begin
        rd_k       <= '0;
        proc_valid <= 1'b0;
      end else begin
        proc_valid <= issue;
        if (issue) begin
          rd_k <= rd_k + 4'd1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_BPP_CODE:    bpp_code    <= cfg_data[2:0];
          REG_ROW_WIDTH:   row_width   <= cfg_data[13:0];
          REG_PIXEL_COLOR: pixel_color <= cfg_data[2:0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire
